// ===== src/battery_charge_estimator_core_assert.svh =====
// Assertion macros used by the battery charge estimator port checker
`ifndef BATTERY_CHARGE_ESTIMATOR_CORE_ASSERT_SVH
`define BATTERY_CHARGE_ESTIMATOR_CORE_ASSERT_SVH

// check pre at an edge implies post at the next edge
`define BCE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bce: next-cycle check failed");

// check pre implies post at the same edge
`define BCE_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bce: same-cycle check failed");

`endif

// ===== src/bce_pkg.sv =====
// Types, constants and curve table of the battery charge estimator
package bce_pkg;

	localparam int unsigned SAMPLES_DEF = 16;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned APB_AW      = 3;

	localparam logic REG_TRIM_NUM = 1'b0;
	localparam logic REG_TRIM_DEN = 1'b1;

	localparam logic [9:0]  TRIM_RESET   = 10'd100;
	localparam logic [7:0]  FAIL_PERCENT = 8'hFF;
	localparam logic [15:0] MV_SAT       = 16'hFFFF;
	localparam logic [12:0] MV_SCALE     = 13'd6600;
	localparam logic [11:0] ADC_FULL     = 12'd4095;
	localparam logic [15:0] MV_FULL      = 16'd4200;
	localparam logic [15:0] MV_EMPTY     = 16'd3400;
	localparam logic [7:0]  PCT_FULL     = 8'd100;
	localparam logic [7:0]  PCT_EMPTY    = 8'd1;

	typedef struct packed {
		logic [11:0] adc_sample;
		logic        conversion_error;
	} sample_t;

	typedef struct packed {
		logic [15:0] battery_millivolts;
		logic [7:0]  charge_percent;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_DIV,
		ST_MV_MUL,
		ST_MV_DIV,
		ST_TRIM_MUL,
		ST_TRIM_DIV,
		ST_TRIM_END,
		ST_CURVE_SEL,
		ST_CURVE_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] lo;
		logic [7:0]  base;
		logic [4:0]  slope;
		logic [11:0] dsr;
	} curve_seg_t;

	function automatic curve_seg_t curve_seg(input logic [15:0] m);
		curve_seg_t s;
		priority if (m >= 16'd4100) s = '{16'd4100, 8'd90, 5'd1, 12'd10};
		else if (m >= 16'd4000) s = '{16'd4000, 8'd80, 5'd1, 12'd10};
		else if (m >= 16'd3900) s = '{16'd3900, 8'd65, 5'd15, 12'd100};
		else if (m >= 16'd3800) s = '{16'd3800, 8'd45, 5'd20, 12'd100};
		else if (m >= 16'd3700) s = '{16'd3700, 8'd25, 5'd20, 12'd100};
		else if (m >= 16'd3600) s = '{16'd3600, 8'd10, 5'd15, 12'd100};
		else s = '{16'd3400, 8'd2, 5'd4, 12'd100};
		return s;
	endfunction

endpackage

// ===== src/battery_charge_estimator_core.sv =====
// Battery charge estimator: sample averaging, trim and LiPo charge curve
// A sample that does not end a batch is added to the sum while the core is idle.
// A batch-ending sample blocks new samples until its result is loaded, while the
// shared divider (two quotient bits a cycle, up to four divisions) works it out.
// A conversion error gives its failure result on the next cycle.
// Reset clears the batch and the result valid and sets both trims to 100.
module battery_charge_estimator_core import bce_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample_data,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	state_t      state_q, state_d;
	logic [15:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [9:0]  num_q, den_q;
	logic [25:0] acc_q, acc_d;
	logic [11:0] rem_q, rem_d, dsr_q;
	logic [3:0]  step_q;
	logic [15:0] trim_q;
	logic [7:0]  base_q;
	result_t     result_q;
	logic        result_valid_q;

	logic        sample_fire, batch_last, out_free, out_load, cfg_write;
	logic [15:0] sum_nxt;
	logic [12:0] mul_a, mul_b;
	logic [25:0] mul_p;
	logic [12:0] t1, t2, r1, r2;
	logic        ge1, ge2;
	logic [22:0] trim_quo;
	curve_seg_t  seg;
	logic [15:0] seg_off;

	assign sample_fire = sample_valid && !sample_stall;
	assign batch_last  = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
	assign sum_nxt     = sum_q + {4'b0, sample_data.adc_sample};
	assign out_free    = !result_valid_q || !result_stall;
	assign trim_quo    = acc_q[22:0];
	assign seg         = curve_seg(trim_q);
	assign seg_off     = trim_q - seg.lo;

	assign t1    = {rem_q, acc_q[25]};
	assign ge1   = (t1 >= {1'b0, dsr_q});
	assign r1    = ge1 ? (t1 - {1'b0, dsr_q}) : t1;
	assign t2    = {r1[11:0], acc_q[24]};
	assign ge2   = (t2 >= {1'b0, dsr_q});
	assign r2    = ge2 ? (t2 - {1'b0, dsr_q}) : t2;
	assign rem_d = r2[11:0];
	assign acc_d = {acc_q[23:0], ge1, ge2};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MV_MUL: begin
				mul_a = acc_q[12:0];
				mul_b = MV_SCALE;
			end
			ST_TRIM_MUL: begin
				mul_a = acc_q[12:0];
				mul_b = {3'b0, num_q};
			end
			ST_CURVE_SEL: begin
				mul_a = {5'b0, seg_off[7:0]};
				mul_b = {8'b0, seg.slope};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_fire && !sample_data.conversion_error && batch_last) begin
					state_d = ST_AVG_DIV;
				end
			end
			ST_AVG_DIV: if (step_q == '0) state_d = ST_MV_MUL;
			ST_MV_MUL: state_d = ST_MV_DIV;
			ST_MV_DIV: if (step_q == '0) state_d = ST_TRIM_MUL;
			ST_TRIM_MUL: begin
				priority if (acc_q[12:0] == '0 || num_q == '0) state_d = ST_DONE;
				else if (den_q == '0) state_d = ST_CURVE_SEL;
				else state_d = ST_TRIM_DIV;
			end
			ST_TRIM_DIV: if (step_q == '0) state_d = ST_TRIM_END;
			ST_TRIM_END: state_d = (trim_quo == '0) ? ST_DONE : ST_CURVE_SEL;
			ST_CURVE_SEL: begin
				if (trim_q >= MV_FULL || trim_q < MV_EMPTY) state_d = ST_DONE;
				else state_d = ST_CURVE_DIV;
			end
			ST_CURVE_DIV: if (step_q == '0) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = (state_q != ST_IDLE) ||
			(sample_data.conversion_error && result_valid_q && result_stall);
		out_load = (state_q == ST_IDLE && sample_fire && sample_data.conversion_error) ||
			(state_q == ST_DONE && out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_IDLE && sample_fire) begin
			if (sample_data.conversion_error || batch_last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (sample_fire && !sample_data.conversion_error && batch_last) begin
					acc_q  <= {sum_nxt, 10'b0};
					rem_q  <= '0;
					dsr_q  <= 12'(SAMPLES_PER_READING);
					step_q <= 4'd7;
				end
			end
			ST_AVG_DIV, ST_MV_DIV, ST_TRIM_DIV, ST_CURVE_DIV: begin
				acc_q  <= acc_d;
				rem_q  <= rem_d;
				step_q <= step_q - 1'b1;
			end
			ST_MV_MUL: begin
				acc_q  <= mul_p;
				rem_q  <= '0;
				dsr_q  <= ADC_FULL;
				step_q <= 4'd12;
			end
			ST_TRIM_MUL: begin
				priority if (acc_q[12:0] == '0 || num_q == '0) begin
					trim_q <= '0;
					base_q <= FAIL_PERCENT;
					acc_q  <= '0;
				end else if (den_q == '0) begin
					trim_q <= MV_SAT;
				end else begin
					acc_q  <= {mul_p[23:0], 2'b0};
					rem_q  <= '0;
					dsr_q  <= {2'b0, den_q};
					step_q <= 4'd11;
				end
			end
			ST_TRIM_END: begin
				trim_q <= (trim_quo > 23'(MV_SAT)) ? MV_SAT : trim_quo[15:0];
				if (trim_quo == '0) begin
					base_q <= FAIL_PERCENT;
					acc_q  <= '0;
				end
			end
			ST_CURVE_SEL: begin
				priority if (trim_q >= MV_FULL) begin
					base_q <= PCT_FULL;
					acc_q  <= '0;
				end else if (trim_q < MV_EMPTY) begin
					base_q <= PCT_EMPTY;
					acc_q  <= '0;
				end else begin
					base_q <= seg.base;
					acc_q  <= {mul_p[11:0], 14'b0};
					rem_q  <= '0;
					dsr_q  <= seg.dsr;
					step_q <= 4'd5;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_IDLE) begin
				result_q <= '{16'd0, FAIL_PERCENT};
			end else begin
				result_q <= '{trim_q, base_q + acc_q[7:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= TRIM_RESET;
			den_q <= TRIM_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_TRIM_NUM: num_q <= pwdata[9:0];
				REG_TRIM_DEN: den_q <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TRIM_NUM: prdata = {22'b0, num_q};
			REG_TRIM_DEN: prdata = {22'b0, den_q};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== src/bce_checker.sv =====
// Port-level checker for the battery charge estimator, with its bind
`include "battery_charge_estimator_core_assert.svh"

module bce_checker import bce_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_stall,
	input sample_t sample_data,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result_data
);

	`BCE_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid)
	`BCE_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result_data))
	`BCE_ASSERT_NEXT(a_error_fails, sample_valid && !sample_stall && sample_data.conversion_error, result_valid && result_data.charge_percent == FAIL_PERCENT && result_data.battery_millivolts == 16'd0)
	`BCE_ASSERT_NOW(a_result_range, result_valid, (result_data.charge_percent == FAIL_PERCENT && result_data.battery_millivolts == 16'd0) || (result_data.charge_percent >= PCT_EMPTY && result_data.charge_percent <= PCT_FULL && result_data.battery_millivolts != 16'd0))

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample_data  (sample_data),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);

// ===== verif/battery_charge_estimator_core_checker.sv =====
// Battery charge estimator checker: predicts readings and register reads, compares both
`timescale 1ns / 100ps
module battery_charge_estimator_checker import bce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  sample_t           sample_data,
	input  logic              result_valid,
	input  logic              result_stall,
	input  result_t           result_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                mismatches,
	output int                outstanding
);

	logic [9:0]  trim_num;
	logic [9:0]  trim_den;
	logic [15:0] batch_sum;
	int unsigned batch_count;
	result_t     expected_readings[$];

	function automatic logic [7:0] soc_percent(input int unsigned m);
		if (m >= MV_FULL) return PCT_FULL;
		if (m >= 4100) return 8'(90 + (m - 4100) / 10);
		if (m >= 4000) return 8'(80 + (m - 4000) / 10);
		if (m >= 3900) return 8'(65 + (m - 3900) * 15 / 100);
		if (m >= 3800) return 8'(45 + (m - 3800) * 20 / 100);
		if (m >= 3700) return 8'(25 + (m - 3700) * 20 / 100);
		if (m >= 3600) return 8'(10 + (m - 3600) * 15 / 100);
		if (m >= MV_EMPTY) return 8'(2 + (m - 3400) * 4 / 100);
		return PCT_EMPTY;
	endfunction

	function automatic result_t reading_from_sum(input logic [15:0] sum,
			input logic [9:0] num, input logic [9:0] den);
		int unsigned avg;
		int unsigned mv;
		int unsigned prod;
		int unsigned trimmed;
		result_t     r;
		avg = sum / SAMPLES_DEF;
		mv = avg * MV_SCALE / ADC_FULL;
		prod = mv * num;
		if (prod == 0) trimmed = 0;
		else if (den == 0) trimmed = MV_SAT;
		else trimmed = prod / den;
		if (trimmed > MV_SAT) trimmed = MV_SAT;
		if (trimmed == 0) begin
			r.battery_millivolts = 16'd0;
			r.charge_percent = FAIL_PERCENT;
		end else begin
			r.battery_millivolts = 16'(trimmed);
			r.charge_percent = soc_percent(trimmed);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_num = TRIM_RESET;
			trim_den = TRIM_RESET;
			batch_sum = '0;
			batch_count = 0;
			expected_readings.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			result_t     got;
			result_t     want;
			result_t     fail_reading;
			logic [31:0] reg_value;
			fail_reading.battery_millivolts = 16'd0;
			fail_reading.charge_percent = FAIL_PERCENT;
			if (result_valid && !result_stall) begin
				got = result_data;
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result, got mv %0d percent %0d", $time,
						got.battery_millivolts, got.charge_percent);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					if (got.battery_millivolts !== want.battery_millivolts) begin
						$display("%0t: battery_millivolts expected %0d, got %0d", $time,
							want.battery_millivolts, got.battery_millivolts);
						mismatches++;
					end
					if (got.charge_percent !== want.charge_percent) begin
						$display("%0t: charge_percent expected %0d, got %0d", $time,
							want.charge_percent, got.charge_percent);
						mismatches++;
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				if (sample_data.conversion_error) begin
					batch_sum = '0;
					batch_count = 0;
					expected_readings.push_back(fail_reading);
				end else begin
					batch_sum = batch_sum + 16'(sample_data.adc_sample);
					batch_count++;
					if (batch_count == SAMPLES_DEF) begin
						expected_readings.push_back(reading_from_sum(batch_sum, trim_num, trim_den));
						batch_sum = '0;
						batch_count = 0;
					end
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_TRIM_DEN) trim_den = pwdata[9:0];
					else trim_num = pwdata[9:0];
				end else begin
					reg_value = (paddr[2] == REG_TRIM_DEN) ? 32'(trim_den) : 32'(trim_num);
					if (prdata !== reg_value) begin
						$display("%0t: register read at %0d expected %0d, got %0d", $time,
							paddr, reg_value, prdata);
						mismatches++;
					end
				end
			end
			outstanding <= expected_readings.size();
		end
	end

endmodule

// ===== verif/tb_battery_charge_estimator_core.sv =====
// Testbench top for the battery charge estimator: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_battery_charge_estimator_core;
	import bce_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 106;
	localparam logic [APB_AW-1:0] ADDR_TRIM_NUM = {REG_TRIM_NUM, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_TRIM_DEN = {REG_TRIM_DEN, 2'b00};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	sample_t           sample_data  = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result_data;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [APB_AW-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;

	int         mismatches;
	int         outstanding;
	int         cycles       = 0;
	int         phase_sent   = 0;
	idle_mode_t idle_mode    = IDLE_NONE;
	logic       hold_req     = 1'b0;
	logic       hold_ack     = 1'b0;
	int         hold_count   = 0;

	battery_charge_estimator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	battery_charge_estimator_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return chance(66);
			IDLE_BOTH:   return chance(6);
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return chance(66);
			IDLE_BOTH:     return chance(6);
			default:       return 1'b0;
		endcase
	endfunction

	// hold off results for a long stretch on each toggle of hold_req
	always @(posedge clk) begin
		if (hold_req != hold_ack && hold_count < HOLD_CYCLES) begin
			result_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_count <= 0;
			end
			result_stall <= receiver_stalls();
		end
	end

	task automatic send_sample(input logic [11:0] value, input logic err);
		while (sender_idles()) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= '{adc_sample: value, conversion_error: err};
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		phase_sent++;
	endtask

	task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
			input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic set_trims(input logic [9:0] num, input logic [9:0] den);
		apb_access(1'b1, ADDR_TRIM_NUM, 32'(num));
		apb_access(1'b1, ADDR_TRIM_DEN, 32'(den));
		apb_access(1'b0, ADDR_TRIM_NUM, 32'd0);
		apb_access(1'b0, ADDR_TRIM_DEN, 32'd0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed batches around the discharge curve, some aborted by errors
	task automatic send_batch();
		int          kind;
		int          base;
		logic [11:0] value;
		kind = $urandom_range(99);
		base = $urandom_range(2680, 2040);
		for (int i = 0; i < SAMPLES_DEF; i++) begin
			if (kind < 10) value = 12'($urandom_range(1));
			else if (kind < 70) value = 12'(base + $urandom_range(16) - 8);
			else if (kind < 90) value = 12'($urandom_range(4095));
			else value = $urandom_range(1) ? 12'hFFF : 12'h000;
			if (chance(3)) send_sample(12'($urandom_range(4095)), 1'b1);
			else send_sample(value, 1'b0);
		end
	endtask

	task automatic pick_trims(input int phase, output logic [9:0] num, output logic [9:0] den);
		case (phase)
			0:       begin num = 10'd100;  den = 10'd100;  end
			1:       begin num = 10'd1023; den = 10'd1;    end
			2:       begin num = 10'd0;    den = 10'd500;  end
			3:       begin num = 10'd700;  den = 10'd0;    end
			4:       begin num = 10'd1;    den = 10'd1023; end
			5:       begin num = 10'd1023; den = 10'd1023; end
			6:       begin num = 10'd1;    den = 10'd1;    end
			11:      begin num = 10'($urandom_range(1023)); den = 10'($urandom_range(1023)); end
			default: begin num = 10'($urandom_range(115, 90)); den = 10'($urandom_range(115, 90)); end
		endcase
	endtask

	initial begin
		logic [9:0] num;
		logic [9:0] den;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_TRIM_NUM, 32'd0);
		apb_access(1'b0, ADDR_TRIM_DEN, 32'd0);
		psel <= 1'b0;
		penable <= 1'b0;

		send_sample(12'hFFF, 1'b1);
		repeat (5) send_sample(12'hFFF, 1'b0);
		send_sample(12'h000, 1'b1);
		repeat (SAMPLES_DEF) send_sample(12'hFFF, 1'b0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			pick_trims(p, num, den);
			set_trims(num, den);
			idle_mode = idle_mode_t'(p % 4);
			if (p == 0) hold_req <= ~hold_req;
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) send_batch();
			wait_drained();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/bce_pkg.sv
src/battery_charge_estimator_core.sv
src/bce_checker.sv
verif/battery_charge_estimator_core_checker.sv
verif/tb_battery_charge_estimator_core.sv
